// ===== rtl/core/dltaq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltaq_pkg
// Shared widths, register indexes, mode codes and types of the dual-level
// threshold alarm qualifier.
// ----------------------------------------------------------------------------
package dltaq_pkg;

  localparam int SAMPLE_BITS = 16;   // sample width, unsigned Q12.4 at 16
  localparam int LIMIT_BITS  = 16;   // limit and split registers, Q12.4
  localparam int RUN_BITS    = 16;   // persistence run counters
  localparam int PERSIST_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  // compare widths wide enough for both operands
  localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
  localparam int CNT_BITS = (RUN_BITS > PERSIST_BITS) ? RUN_BITS : PERSIST_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MONITOR_MODE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INCLUSIVE      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_SPLIT     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARN_LOW       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALARM_LOW      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARN_HIGH      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALARM_HIGH     = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERSIST_COUNT  = 3'd7;

  // monitor modes; the unused code behaves as banded
  localparam logic [1:0] MODE_LOW    = 2'd0;
  localparam logic [1:0] MODE_HIGH   = 2'd1;
  localparam logic [1:0] MODE_BANDED = 2'd2;

  // reset values
  localparam logic [1:0]              RST_MODE       = MODE_BANDED;
  localparam logic [LIMIT_BITS-1:0]   RST_BAND_SPLIT = 16'd1152;  // 72.0
  localparam logic [LIMIT_BITS-1:0]   RST_LOW_LIMIT  = 16'd0;
  localparam logic [LIMIT_BITS-1:0]   RST_HIGH_LIMIT = 16'hFFFF;
  localparam logic [PERSIST_BITS-1:0] RST_PERSIST    = 16'd10;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [LIMIT_BITS-1:0]   limit_t;
  typedef logic [RUN_BITS-1:0]     run_t;
  typedef logic [PERSIST_BITS-1:0] persist_t;

  typedef struct packed {
    logic warn;
    logic alarm;
  } side_flags_t;

  typedef struct packed {
    run_t        warn_run;
    run_t        alarm_run;
    side_flags_t flags;
  } side_state_t;

endpackage

// ===== rtl/core/dual_level_threshold_alarm_qualifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_level_threshold_alarm_qualifier_top
// Low/high warning and alarm qualifier with persistence counting on a
// stream of Q12.4 sensor samples.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-----------------
//  in       | in_sample_value                           | in_valid/in_ready
//  out      | out_low_warning, out_low_alarm,           | out_valid/out_ready
//           | out_high_warning, out_high_alarm          |
//  cfg      | cfg_index, cfg_wdata                      | cfg_we, no wait
//
// One beat per cycle while in_ready is high; each result appears in the cycle
// after its sample beat, from the single compare-and-count step on the run
// counters, which closes within the accepting cycle.
// in_ready is high when the output register is empty or being drained.
// Reset (sync, rst_n low) clears counters and flags and loads register defaults.
// ----------------------------------------------------------------------------
module dual_level_threshold_alarm_qualifier_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  dltaq_pkg::sample_t                     in_sample_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_low_warning,
  output logic                                   out_low_alarm,
  output logic                                   out_high_warning,
  output logic                                   out_high_alarm,
  input  logic                                   cfg_we,
  input  logic [dltaq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dltaq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import dltaq_pkg::*;

  // configuration
  logic [1:0]  monitor_mode_r;
  logic        inclusive_r;
  limit_t      band_split_r;
  limit_t      warn_low_r;
  limit_t      alarm_low_r;
  limit_t      warn_high_r;
  limit_t      alarm_high_r;
  persist_t    persist_r;

  // per-side state
  side_state_t low_r;
  side_state_t high_r;
  side_state_t low_nxt;
  side_state_t high_nxt;

  logic        out_valid_r;
  side_flags_t out_low_r;
  side_flags_t out_high_r;

  logic        accept;
  logic        use_high;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_mode_r <= RST_MODE;
      inclusive_r    <= 1'b0;
      band_split_r   <= RST_BAND_SPLIT;
      warn_low_r     <= RST_LOW_LIMIT;
      alarm_low_r    <= RST_LOW_LIMIT;
      warn_high_r    <= RST_HIGH_LIMIT;
      alarm_high_r   <= RST_HIGH_LIMIT;
      persist_r      <= RST_PERSIST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MONITOR_MODE:  monitor_mode_r <= cfg_wdata[1:0];
        REG_INCLUSIVE:     inclusive_r    <= cfg_wdata[0];
        REG_BAND_SPLIT:    band_split_r   <= cfg_wdata[LIMIT_BITS-1:0];
        REG_WARN_LOW:      warn_low_r     <= cfg_wdata[LIMIT_BITS-1:0];
        REG_ALARM_LOW:     alarm_low_r    <= cfg_wdata[LIMIT_BITS-1:0];
        REG_WARN_HIGH:     warn_high_r    <= cfg_wdata[LIMIT_BITS-1:0];
        REG_ALARM_HIGH:    alarm_high_r   <= cfg_wdata[LIMIT_BITS-1:0];
        REG_PERSIST_COUNT: persist_r      <= cfg_wdata[PERSIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (monitor_mode_r)
      MODE_LOW:  use_high = 1'b0;
      MODE_HIGH: use_high = 1'b1;
      default:   use_high = CMP_BITS'(in_sample_value) > CMP_BITS'(band_split_r);
    endcase
  end

  dltaq_side u_low (
    .high_side   (1'b0),
    .inclusive   (inclusive_r),
    .sample      (in_sample_value),
    .warn_limit  (warn_low_r),
    .alarm_limit (alarm_low_r),
    .persist     (persist_r),
    .cur         (low_r),
    .nxt         (low_nxt)
  );

  dltaq_side u_high (
    .high_side   (1'b1),
    .inclusive   (inclusive_r),
    .sample      (in_sample_value),
    .warn_limit  (warn_high_r),
    .alarm_limit (alarm_high_r),
    .persist     (persist_r),
    .cur         (high_r),
    .nxt         (high_nxt)
  );

  // the side not evaluated drops its flags and keeps its run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (use_high) begin
          high_r       <= high_nxt;
          low_r.flags  <= '0;
        end else begin
          low_r        <= low_nxt;
          high_r.flags <= '0;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_low_r  <= use_high ? side_flags_t'('0) : low_nxt.flags;
      out_high_r <= use_high ? high_nxt.flags : side_flags_t'('0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_low_warning  = out_low_r.warn;
  assign out_low_alarm    = out_low_r.alarm;
  assign out_high_warning = out_high_r.warn;
  assign out_high_alarm   = out_high_r.alarm;

`ifndef SYNTHESIS
  // only one side can report at a time
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_low_r.warn || out_low_r.alarm) &&
                      (out_high_r.warn || out_high_r.alarm)))
    else $error("both sides flagged in one result");

  // output beat always follows an accepted sample
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted sample produced no result");

  // low-only mode never raises high flags
  a_low_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && monitor_mode_r == MODE_LOW) |=>
      (!out_high_r.warn && !out_high_r.alarm))
    else $error("high flag in low-only mode");

  // result flags mirror the stored flag state
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_low_r == low_r.flags) && (out_high_r == high_r.flags))
    else $error("result flags differ from state");
`endif

endmodule

// ===== rtl/core/dltaq_side.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltaq_side
// Next-state logic of one side: warning level then alarm level, each with a
// persistence run counter. Purely combinational.
// ----------------------------------------------------------------------------
module dltaq_side (
  input  logic                   high_side,   // 1: trigger above, 0: below
  input  logic                   inclusive,
  input  dltaq_pkg::sample_t     sample,
  input  dltaq_pkg::limit_t      warn_limit,
  input  dltaq_pkg::limit_t      alarm_limit,
  input  dltaq_pkg::persist_t    persist,
  input  dltaq_pkg::side_state_t cur,
  output dltaq_pkg::side_state_t nxt
);
  import dltaq_pkg::*;

  logic [CMP_BITS-1:0] s_ext;
  logic [CMP_BITS-1:0] wl_ext;
  logic [CMP_BITS-1:0] al_ext;
  logic                warn_trig;
  logic                alarm_trig;
  run_t                warn_inc;
  run_t                alarm_inc;
  logic                warn_set;
  logic                alarm_set;

  function automatic logic passes(input logic [CMP_BITS-1:0] s,
                                  input logic [CMP_BITS-1:0] lim,
                                  input logic hi, input logic incl);
    if (hi) begin
      return incl ? (s >= lim) : (s > lim);
    end else begin
      return incl ? (s <= lim) : (s < lim);
    end
  endfunction

  function automatic run_t sat_inc(input run_t r);
    return (r != {RUN_BITS{1'b1}}) ? r + 1'b1 : r;
  endfunction

  function automatic logic exceeds(input run_t r, input persist_t p);
    return CNT_BITS'(r) > CNT_BITS'(p);
  endfunction

  assign s_ext  = CMP_BITS'(sample);
  assign wl_ext = CMP_BITS'(warn_limit);
  assign al_ext = CMP_BITS'(alarm_limit);

  assign warn_trig  = passes(s_ext, wl_ext, high_side, inclusive);
  assign alarm_trig = passes(s_ext, al_ext, high_side, inclusive);

  assign warn_inc  = sat_inc(cur.warn_run);
  assign alarm_inc = sat_inc(cur.alarm_run);

  assign warn_set  = warn_trig  && exceeds(warn_inc, persist);
  assign alarm_set = alarm_trig && exceeds(alarm_inc, persist);

  always_comb begin
    nxt.warn_run  = (!warn_trig || warn_set) ? '0 : warn_inc;
    nxt.alarm_run = (!alarm_trig || alarm_set) ? '0 : alarm_inc;
    nxt.flags.alarm = alarm_trig && (cur.flags.alarm || alarm_set);
    // a fresh alarm knocks down the warning of its side
    nxt.flags.warn  = warn_trig && (cur.flags.warn || warn_set) && !alarm_set;
  end

endmodule
